[rtl/sync_framed_command_recognizer_assert.svh]
// Assertion macros shared by the RTL files.
`ifndef SYNC_FRAMED_COMMAND_RECOGNIZER_ASSERT_SVH
`define SYNC_FRAMED_COMMAND_RECOGNIZER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SFCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SFCR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

[rtl/sfcr_pkg.sv]
`default_nettype none
package sfcr_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte SYNC_CHAR = 8'h24;
    localparam t_byte LF_CHAR   = 8'h0A;
    localparam t_byte CR_CHAR   = 8'h0D;

    localparam int NUM_WORDS = 10;
    localparam logic [3:0] CMD_UNKNOWN = 4'd10;

    localparam int QDEPTH = 4;

    // Command words, right-justified, first character in the highest used byte.
    localparam logic [87:0] WORD_TEXT [NUM_WORDS] = '{
        88'("id"), 88'("ver"), 88'("seta:"), 88'("getseta"), 88'("geta"),
        88'("getadc0"), 88'("adccal0"), 88'("adccalh:"), 88'("adccalstore"),
        88'("adccalget")
    };
    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd2, 4'd3, 4'd5, 4'd7, 4'd4, 4'd7, 4'd7, 4'd8, 4'd11, 4'd9
    };
    // Prefix words: seta: and adccalh:
    localparam logic [NUM_WORDS-1:0] WORD_PREFIX = 10'b0010000100;

    typedef enum logic [2:0] {
        MODE_HUNT0,
        MODE_HUNT1,
        MODE_HUNT2,
        MODE_HUNT3,
        MODE_BODY
    } t_mode;

    typedef enum logic [1:0] {
        REQ_START,
        REQ_COMMIT,
        REQ_FINISH,
        REQ_EMPTY
    } t_req_kind;

    typedef struct packed {
        t_req_kind kind;
        logic      commit;
        t_byte     data;
    } t_req;

    // Character at position pos of word idx; pos must be below the word length.
    function automatic t_byte word_char(input int unsigned idx, input logic [3:0] pos);
        logic [3:0] sh;
        sh = WORD_LEN[idx] - pos - 4'd1;
        return WORD_TEXT[idx][{sh, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

[rtl/sfcr_front.sv]
`default_nettype none
module sfcr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sfcr_pkg::t_byte i_byte,
    output logic               o_ready,
    input  wire logic          i_full,
    output logic               o_push,
    output sfcr_pkg::t_req     o_req
);
    import sfcr_pkg::*;

    t_mode r_mode, n_mode;
    t_byte r_held, n_held;
    logic  w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    always_comb begin
        n_mode = r_mode;
        if (w_acc) begin
            case (r_mode)
                MODE_BODY: begin
                    if (i_byte == SYNC_CHAR) begin
                        n_mode = MODE_HUNT1;
                    end else if (i_byte == LF_CHAR) begin
                        n_mode = MODE_HUNT0;
                    end
                end
                MODE_HUNT0: n_mode = (i_byte == SYNC_CHAR) ? MODE_HUNT1 : MODE_HUNT0;
                MODE_HUNT1: n_mode = (i_byte == SYNC_CHAR) ? MODE_HUNT2 : MODE_HUNT0;
                MODE_HUNT2: n_mode = (i_byte == SYNC_CHAR) ? MODE_HUNT3 : MODE_HUNT0;
                MODE_HUNT3: begin
                    if (i_byte == SYNC_CHAR) begin
                        n_mode = MODE_HUNT3;
                    end else if (i_byte == LF_CHAR) begin
                        n_mode = MODE_HUNT0;
                    end else begin
                        n_mode = MODE_BODY;
                    end
                end
                default: n_mode = MODE_HUNT0;
            endcase
        end
    end

    always_comb begin
        o_push      = 1'b0;
        o_req.kind  = REQ_COMMIT;
        o_req.commit = 1'b0;
        o_req.data  = r_held;
        n_held      = r_held;
        if (w_acc) begin
            case (r_mode)
                MODE_BODY: begin
                    if (i_byte == LF_CHAR) begin
                        o_push       = 1'b1;
                        o_req.kind   = REQ_FINISH;
                        o_req.commit = (r_held != CR_CHAR);
                    end else if (i_byte != SYNC_CHAR) begin
                        o_push       = 1'b1;
                        o_req.kind   = REQ_COMMIT;
                        o_req.commit = 1'b1;
                        n_held       = i_byte;
                    end
                end
                MODE_HUNT3: begin
                    if (i_byte == LF_CHAR) begin
                        o_push     = 1'b1;
                        o_req.kind = REQ_EMPTY;
                    end else if (i_byte != SYNC_CHAR) begin
                        o_push     = 1'b1;
                        o_req.kind = REQ_START;
                        n_held     = i_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUNT0;
        end else begin
            r_mode <= n_mode;
        end
        r_held <= n_held;
    end

endmodule
`default_nettype wire

[rtl/sfcr_queue.sv]
`default_nettype none
module sfcr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfcr_pkg::t_req i_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output sfcr_pkg::t_req     o_head,
    output logic               o_empty
);
    import sfcr_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_req             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "sync_framed_command_recognizer_assert.svh"
    `SFCR_ASSERT(a_q_bound, r_count <= QCW'(QDEPTH), "queue count beyond depth")
    `SFCR_ASSERT(a_q_pop_empty, !(i_pop && o_empty), "pop from empty queue")
    `SFCR_ASSERT_NEXT(a_q_inc, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count lost")

endmodule
`default_nettype wire

[rtl/sfcr_back.sv]
`default_nettype none
module sfcr_back #(
    parameter int BODY_COUNT_MAX = 255
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfcr_pkg::t_req i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [3:0]         o_command,
    output logic [7:0]         o_length
);
    import sfcr_pkg::*;

    localparam int CW = $clog2(BODY_COUNT_MAX + 1);

    logic [NUM_WORDS-1:0] r_cand, n_cand, c_cand;
    logic [CW-1:0]        r_count, n_count, c_count;
    logic                 r_out_valid;
    logic [3:0]           r_cmd, c_cmd;
    logic [7:0]           r_len, c_len;
    logic                 w_commit, w_need_out, w_out_free;

    assign w_commit   = (i_head.kind == REQ_COMMIT) ||
                        ((i_head.kind == REQ_FINISH) && i_head.commit);
    assign w_need_out = (i_head.kind == REQ_FINISH) || (i_head.kind == REQ_EMPTY);
    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = !i_empty && (!w_need_out || w_out_free);

    always_comb begin
        c_cand  = r_cand;
        c_count = r_count;
        if (w_commit) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                if (32'(r_count) < 32'(WORD_LEN[i])) begin
                    if (word_char(i, r_count[3:0]) != i_head.data) begin
                        c_cand[i] = 1'b0;
                    end
                end else if (!WORD_PREFIX[i]) begin
                    c_cand[i] = 1'b0;
                end
            end
            if (r_count != CW'(BODY_COUNT_MAX)) begin
                c_count = r_count + 1'b1;
            end
        end
        c_cmd = CMD_UNKNOWN;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (c_cand[i] && (WORD_PREFIX[i] ? (32'(c_count) >= 32'(WORD_LEN[i]))
                                             : (32'(c_count) == 32'(WORD_LEN[i])))) begin
                c_cmd = 4'(i);
            end
        end
        c_len = (32'(c_count) > 32'd255) ? 8'd255 : 8'(c_count);
        if (i_head.kind == REQ_EMPTY) begin
            c_cmd = CMD_UNKNOWN;
            c_len = 8'd0;
        end
    end

    always_comb begin
        n_cand  = r_cand;
        n_count = r_count;
        if (o_pop) begin
            case (i_head.kind)
                REQ_START: begin
                    n_cand  = '1;
                    n_count = '0;
                end
                REQ_COMMIT, REQ_FINISH: begin
                    n_cand  = c_cand;
                    n_count = c_count;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand      <= '1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cand  <= n_cand;
            r_count <= n_count;
            if (o_pop && w_need_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop && w_need_out) begin
            r_cmd <= c_cmd;
            r_len <= c_len;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_command = r_cmd;
    assign o_length  = r_len;

`include "sync_framed_command_recognizer_assert.svh"
    `SFCR_ASSERT(a_cnt_sat, 32'(r_count) <= BODY_COUNT_MAX, "body count beyond maximum")

endmodule
`default_nettype wire

[rtl/sync_framed_command_recognizer.sv]
// Channel   Dir  Signals                      Payload
// s_axis    in   tvalid tready tdata[7:0]     rx_byte
// m_axis    out  tvalid tready tdata[15:0]    command[3:0], body_length[11:4]
//
// One byte per cycle on s_axis while tready is high; results are registered
// behind the queue. The front end runs the framing FSM, the back end the word
// matcher, one request per cycle unless a result waits, via a four-entry queue.
// s_axis_tready drops only when the queue fills while a result waits on m_axis.
// Synchronous reset clears all control state.
`default_nettype none
module sync_framed_command_recognizer #(
    parameter int BODY_COUNT_MAX = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [3:0] command, [11:4] body_length
);
    import sfcr_pkg::*;

    t_req       w_req, w_head;
    logic       w_push, w_full, w_pop, w_empty;
    logic [3:0] w_cmd;
    logic [7:0] w_len;

    sfcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_req   (w_req)
    );

    sfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    sfcr_back #(
        .BODY_COUNT_MAX (BODY_COUNT_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_command (w_cmd),
        .o_length  (w_len)
    );

    assign m_axis_tdata = {4'b0000, w_len, w_cmd};

endmodule
`default_nettype wire

[tb/sfcr_frame_checker.sv]
`default_nettype none
module sfcr_frame_checker #(
    parameter int BODY_COUNT_MAX = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [3:0] command, [11:4] body_length
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfcr_pkg::*;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] body_length;
    } t_frame_result;

    localparam logic [NUM_WORDS-1:0] PREFIX_WORDS = 10'b0010000100;

    string known_words [NUM_WORDS] = '{
        "id", "ver", "seta:", "getseta", "geta",
        "getadc0", "adccal0", "adccalh:", "adccalstore", "adccalget"
    };

    t_mode                 hunt_mode;
    logic [NUM_WORDS-1:0]  live_words;
    int unsigned           body_bytes;
    t_byte                 held;
    logic                  held_ok;

    t_frame_result         frames_due [$];
    int                    fail_total = 0;
    int                    pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic void open_body();
        live_words = '1;
        body_bytes = 0;
        held       = '0;
        held_ok    = 1'b0;
    endfunction

    function automatic void match_body_byte(input t_byte b);
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (live_words[i]) begin
                if (body_bytes < known_words[i].len()) begin
                    if (t_byte'(known_words[i][body_bytes]) != b)
                        live_words[i] = 1'b0;
                end else if (!PREFIX_WORDS[i]) begin
                    live_words[i] = 1'b0;
                end
            end
        end
        if (body_bytes < BODY_COUNT_MAX)
            body_bytes++;
    endfunction

    function automatic logic [3:0] pick_command();
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (live_words[i]) begin
                if (PREFIX_WORDS[i] ? (body_bytes >= known_words[i].len())
                                    : (body_bytes == known_words[i].len()))
                    return 4'(i);
            end
        end
        return CMD_UNKNOWN;
    endfunction

    // Returns 1 when the byte completes a frame.
    function automatic bit parse_rx(input t_byte b, output t_frame_result res);
        res = '0;
        if (hunt_mode == MODE_BODY) begin
            if (b == SYNC_CHAR) begin
                hunt_mode = MODE_HUNT1;
                return 1'b0;
            end
            if (b == LF_CHAR) begin
                if (held_ok && held != CR_CHAR)
                    match_body_byte(held);
                held_ok = 1'b0;
                res.command     = pick_command();
                res.body_length = (body_bytes > 255) ? 8'd255 : 8'(body_bytes);
                hunt_mode = MODE_HUNT0;
                return 1'b1;
            end
            if (held_ok)
                match_body_byte(held);
            held    = b;
            held_ok = 1'b1;
            return 1'b0;
        end
        if (b == SYNC_CHAR) begin
            if (hunt_mode != MODE_HUNT3)
                hunt_mode = t_mode'(hunt_mode + 3'd1);
            return 1'b0;
        end
        if (hunt_mode == MODE_HUNT3) begin
            open_body();
            if (b == LF_CHAR) begin
                res.command     = CMD_UNKNOWN;
                res.body_length = '0;
                hunt_mode = MODE_HUNT0;
                return 1'b1;
            end
            held      = b;
            held_ok   = 1'b1;
            hunt_mode = MODE_BODY;
            return 1'b0;
        end
        hunt_mode = MODE_HUNT0;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        t_frame_result pred;
        if (!i_rst_n) begin
            hunt_mode = MODE_HUNT0;
            open_body();
            frames_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.command     = m_axis_tdata[3:0];
                got.body_length = m_axis_tdata[11:4];
                if (frames_due.size() == 0) begin
                    fail_total++;
                    $display("%t: unexpected result: expected none, got command %0d length %0d",
                             $time, got.command, got.body_length);
                end else begin
                    want = frames_due.pop_front();
                    if (got.command != want.command) begin
                        fail_total++;
                        $display("%t: command mismatch: expected %0d, got %0d",
                                 $time, want.command, got.command);
                    end
                    if (got.body_length != want.body_length) begin
                        fail_total++;
                        $display("%t: body_length mismatch: expected %0d, got %0d",
                                 $time, want.body_length, got.body_length);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready && parse_rx(s_axis_tdata, pred))
                frames_due.push_back(pred);
        end
        pending_total = frames_due.size();
    end

endmodule
`default_nettype wire

[tb/sync_framed_command_recognizer_tb.sv]
`default_nettype none
module sync_framed_command_recognizer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfcr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [3:0] command, [11:4] body_length

    int          fail_count;
    int          pending;

    t_byte       rx_stream [$];

    string sample_words [NUM_WORDS] = '{
        "id", "ver", "seta:", "getseta", "geta",
        "getadc0", "adccal0", "adccalh:", "adccalstore", "adccalget"
    };

    sync_framed_command_recognizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sfcr_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            rx_stream.push_back(t_byte'(s[k]));
    endfunction

    // Any byte that keeps a body going; CR favoured a little.
    function automatic t_byte body_byte();
        t_byte v;
        if ($urandom_range(0, 15) == 0)
            return CR_CHAR;
        do
            v = t_byte'($urandom_range(0, 255));
        while (v == SYNC_CHAR || v == LF_CHAR);
        return v;
    endfunction

    function automatic void add_long_frame(input bit with_prefix);
        put_text("$$$");
        if (with_prefix)
            put_text("adccalh:");
        repeat (290) rx_stream.push_back(body_byte());
        put_text("\r\n");
    endfunction

    function automatic void add_random_frame();
        int    kind;
        int    pos;
        string w;
        t_byte body [$];
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // line noise, possibly a broken sync
            repeat ($urandom_range(1, 8))
                rx_stream.push_back(t_byte'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                put_text("$$");
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_text("$");
        put_text("$$$");
        w = sample_words[$urandom_range(0, NUM_WORDS - 1)];
        for (int k = 0; k < w.len(); k++)
            body.push_back(t_byte'(w[k]));
        if (kind < 48) begin
        end else if (kind < 60) begin
            repeat ($urandom_range(1, 6)) body.push_back(body_byte());
        end else if (kind < 70) begin
            pos = $urandom_range(0, body.size() - 1);
            if ($urandom_range(0, 1))
                body[pos] = body[pos] ^ 8'h20;
            else
                body[pos] = body_byte();
        end else if (kind < 76) begin
            repeat ($urandom_range(1, body.size())) void'(body.pop_back());
        end else if (kind < 90) begin
            body.delete();
            repeat ($urandom_range(0, 12)) body.push_back(body_byte());
        end else begin
            // frame dropped by a sync byte inside the body
            repeat ($urandom_range(0, body.size())) void'(body.pop_back());
            foreach (body[k]) rx_stream.push_back(body[k]);
            put_text("$");
            return;
        end
        foreach (body[k]) rx_stream.push_back(body[k]);
        if ($urandom_range(0, 1))
            rx_stream.push_back(CR_CHAR);
        rx_stream.push_back(LF_CHAR);
    endfunction

    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 700 && cyc < 950)
                m_axis_tready <= 1'b0;
            else if (cyc >= 1600 && cyc < 2200)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 29);
        end
    end

    initial begin
        int next_item;
        int frames;
        int drain;
        bit calm;

        put_text("\n$$$\n");
        put_text("$$$\r\n");
        put_text("$$$$$id\n");
        put_text("$$x$$$ver\r\n");
        put_text("$$$ad$$$ID\n");
        put_text("$$$i\rd\n$$$\r\r\n");
        put_text("$$$");
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        put_text("\n");
        foreach (sample_words[i]) begin
            put_text("$$$");
            put_text(sample_words[i]);
            if (i % 2)
                put_text("\r\n");
            else
                put_text("\n");
        end
        put_text("$$$seta:7\n$$$adccalh:1.5\r\n$$$getadc\n");

        frames = 0;
        while (rx_stream.size() < 1950) begin
            if (frames == 30 || frames == 110)
                add_long_frame(frames == 30);
            else
                add_random_frame();
            frames++;
        end
        put_text("$$$id\n");

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        next_item = 0;
        while (next_item < rx_stream.size() || s_axis_tvalid) begin
            @(posedge i_clk);
            if (!s_axis_tvalid || s_axis_tready) begin
                calm = (next_item >= 900 && next_item < 1300);
                if (next_item < rx_stream.size() && (calm || $urandom_range(0, 99) >= 29)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_stream[next_item];
                    next_item++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end

        @(posedge i_clk);
        drain = 0;
        while (pending != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/sfcr_pkg.sv
rtl/sfcr_front.sv
rtl/sfcr_queue.sv
rtl/sfcr_back.sv
rtl/sync_framed_command_recognizer.sv
tb/sfcr_frame_checker.sv
tb/sync_framed_command_recognizer_tb.sv
